/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/udiv_pkg.sv */
// ----------------------------------------------------------------------------
// udiv_pkg
// Widths and stage payload types of the pipelined restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

package udiv_pkg;

	localparam int DIVIDEND_BITS = 64;
	localparam int DIVISOR_BITS  = 32;
	localparam int PART_W        = DIVISOR_BITS + 1;
	localparam int IN_TDATA_W    = ((DIVIDEND_BITS + DIVISOR_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = ((DIVIDEND_BITS + DIVISOR_BITS + 7) / 8) * 8;

	// Work carried down the pipeline. nq shifts dividend bits out at the top
	// and quotient bits in at the bottom; after the last step it is the quotient.
	typedef struct packed {
		logic [PART_W-1:0]        part;
		logic [DIVIDEND_BITS-1:0] nq;
		logic [DIVISOR_BITS-1:0]  den;
	} udiv_work_t;

	typedef struct packed {
		logic [DIVISOR_BITS-1:0]  rem;
		logic [DIVIDEND_BITS-1:0] quo;
	} udiv_res_t;

endpackage

`default_nettype wire

/* rtl/core/unsigned_divide_64_by_32.sv */
// Each request passes through the 64 step stages, the first loaded at the
// accepting edge, and then through the output register to m_tvalid.
// Throughput: one division per cycle while not frozen; each stage holds one
// 33-bit subtract. A two-entry output buffer (output register plus skid) keeps
// s_tready registered; the pipeline freezes only when both entries are full.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// unsigned_divide_64_by_32
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module unsigned_divide_64_by_32 (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// tdata: dividend [63:0], divisor [95:64]
	input  wire logic [udiv_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// tdata: quotient [63:0], remainder [95:64]
	output logic [udiv_pkg::OUT_TDATA_W-1:0]          m_tdata
);
	import udiv_pkg::*;

	logic [DIVIDEND_BITS:0] stage_valid;
	udiv_work_t             stage_work [DIVIDEND_BITS+1];
	logic                   en;
	logic                   out_valid_q;
	logic                   sk_valid_q;
	udiv_res_t              out_q;
	udiv_res_t              sk_q;
	udiv_res_t              last_res;

	assign en       = !sk_valid_q;
	assign s_tready = en;

	assign stage_valid[0]     = s_tvalid;
	assign stage_work[0].part = '0;
	assign stage_work[0].nq   = s_tdata[DIVIDEND_BITS-1:0];
	assign stage_work[0].den  = s_tdata[DIVIDEND_BITS +: DIVISOR_BITS];

	for (genvar i = 0; i < DIVIDEND_BITS; i++) begin : g_stage
		udiv_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (stage_valid[i]),
			.in_work   (stage_work[i]),
			.out_valid (stage_valid[i+1]),
			.out_work  (stage_work[i+1])
		);
	end

	assign last_res.quo = stage_work[DIVIDEND_BITS].nq;
	assign last_res.rem = stage_work[DIVIDEND_BITS].part[DIVISOR_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (sk_valid_q) begin
			if (m_tready) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end
		end else if (stage_valid[DIVIDEND_BITS]) begin
			// park the new result when the output register is stalled
			if (out_valid_q && !m_tready) begin
				sk_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (m_tready) begin
				out_q <= sk_q;
			end
		end else if (stage_valid[DIVIDEND_BITS]) begin
			if (out_valid_q && !m_tready) begin
				sk_q <= last_res;
			end else begin
				out_q <= last_res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

	`ASSERT_IMPL(a_skid_behind_out, sk_valid_q, out_valid_q,
		"skid full with empty output register")
	`ASSERT_NEXT(a_skid_catch,
		!sk_valid_q && out_valid_q && !m_tready && stage_valid[DIVIDEND_BITS],
		sk_valid_q, "stalled result not parked in skid")
	`ASSERT_NEXT(a_skid_drain, sk_valid_q && m_tready, out_valid_q && !sk_valid_q,
		"skid not drained into output register")
	`ASSERT_IMPL(a_rem_below_den,
		stage_valid[DIVIDEND_BITS] && (stage_work[DIVIDEND_BITS].den != '0),
		stage_work[DIVIDEND_BITS].part < {1'b0, stage_work[DIVIDEND_BITS].den},
		"remainder not below divisor")

endmodule

`default_nettype wire

/* rtl/core/udiv_stage.sv */
// ----------------------------------------------------------------------------
// udiv_stage
// One restoring division step followed by its pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire udiv_pkg::udiv_work_t in_work,
	output logic                     out_valid,
	output udiv_pkg::udiv_work_t     out_work
);
	import udiv_pkg::*;

	logic [PART_W-1:0] shifted;
	logic [PART_W:0]   diff;
	logic              ge;
	udiv_work_t        nxt;
	logic              valid_s1;
	udiv_work_t        work_s1;

	always_comb begin
		// Top bit of the partial remainder is zero for any nonzero divisor;
		// drop it so a zero divisor keeps the low dividend bits.
		shifted    = {in_work.part[PART_W-2:0], in_work.nq[DIVIDEND_BITS-1]};
		diff       = {1'b0, shifted} - {2'b00, in_work.den};
		ge         = !diff[PART_W];
		nxt.part   = ge ? diff[PART_W-1:0] : shifted;
		nxt.nq     = {in_work.nq[DIVIDEND_BITS-2:0], ge};
		nxt.den    = in_work.den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			work_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams operand pairs into the 64-by-32 unsigned divider with random
// bursts of idle and stall cycles on both sides. Each accepted request is
// divided here by a 33-bit restoring loop, and each accepted result is
// checked field by field against the oldest quotient and remainder waiting.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_W      = udiv_pkg::DIVIDEND_BITS;
	localparam int DEN_W      = udiv_pkg::DIVISOR_BITS;
	localparam int RANDOM_OPS = 900;
	localparam int TAIL_OPS   = 120;
	localparam int DRAIN_WAIT = 80;
	localparam int CYCLE_CAP  = 300000;

	typedef struct packed {
		logic [DEN_W-1:0] divisor;
		logic [NUM_W-1:0] dividend;
	} operand_pair_t;

	typedef struct packed {
		logic [DEN_W-1:0] remainder;
		logic [NUM_W-1:0] quotient;
	} quotient_pair_t;

	logic                              clk      = 1'b0;
	logic                              arst_n   = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [udiv_pkg::IN_TDATA_W-1:0]   s_tdata  = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [udiv_pkg::OUT_TDATA_W-1:0]  m_tdata;

	operand_pair_t  pending_operands[$];
	quotient_pair_t expected_quotients[$];
	operand_pair_t  next_operands;
	quotient_pair_t want;
	quotient_pair_t got;
	logic           request_taken  = 1'b0;
	bit             tail_phase     = 1'b0;
	int             send_gap       = 0;
	int             stall_gap      = 0;
	int             mismatch_count = 0;

	unsigned_divide_64_by_32 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Restoring division, one quotient bit per step, with a partial remainder
	// one bit wider than the divisor.
	function automatic quotient_pair_t divide_restoring(input logic [NUM_W-1:0] num,
			input logic [DEN_W-1:0] den);
		logic [DEN_W:0] part;
		quotient_pair_t res;
		part = '0;
		res  = '0;
		if (den == '0) begin
			res.quotient  = '1;
			res.remainder = num[DEN_W-1:0];
			return res;
		end
		for (int i = NUM_W - 1; i >= 0; i--) begin
			part = {part[DEN_W-1:0], num[i]};
			if (part >= {1'b0, den}) begin
				part           = part - {1'b0, den};
				res.quotient[i] = 1'b1;
			end
		end
		res.remainder = part[DEN_W-1:0];
		return res;
	endfunction

	function automatic logic [NUM_W-1:0] random_wide();
		return {$urandom, $urandom};
	endfunction

	task automatic queue_operands(input logic [NUM_W-1:0] num, input logic [DEN_W-1:0] den);
		operand_pair_t op;
		op.dividend = num;
		op.divisor  = den;
		pending_operands.push_back(op);
	endtask

	task automatic queue_random_operands();
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] quo;
		num = random_wide();
		den = $urandom;
		case ($urandom_range(0, 11))
			0, 1, 2: ;
			3, 4: den = $urandom_range(1, 16);
			5: den = {1'b1, den[DEN_W-2:0]};
			6: num = {32'h0, num[31:0]};
			7, 8: begin
				// build dividend from a known quotient and remainder
				if (den == '0)
					den = 1;
				quo = $urandom;
				num = 64'(quo) * 64'(den) + 64'($urandom_range(0, 32'(den - 1)));
			end
			9: num = '1 - 64'($urandom_range(0, 255));
			10: den = '1 - 32'($urandom_range(0, 15));
			default: begin
				if ($urandom_range(0, 1) == 0)
					den = '0;
			end
		endcase
		queue_operands(num, den);
	endtask

	// Hold until the driver has sent everything and every result has arrived.
	task automatic wait_for_drain();
		while (pending_operands.size() != 0 || s_tvalid || expected_quotients.size() != 0)
			@(posedge clk);
	endtask

	// Sender: present a new request once the previous one is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || request_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
				send_gap = $urandom_range(0, 3);
				s_tvalid <= 1'b0;
			end else if (pending_operands.size() != 0) begin
				next_operands = pending_operands.pop_front();
				s_tdata  <= next_operands;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall in short bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_gap > 0) begin
			stall_gap--;
			m_tready <= 1'b0;
		end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
			stall_gap = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Check results before recording new requests from the same edge.
	always @(posedge clk) begin
		request_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_quotients.size() == 0) begin
				$error("unexpected result: quotient %h, remainder %h", got.quotient,
					got.remainder);
				mismatch_count++;
			end else begin
				want = expected_quotients.pop_front();
				if (got.quotient !== want.quotient) begin
					$error("quotient: expected %h, actual %h", want.quotient, got.quotient);
					mismatch_count++;
				end
				if (got.remainder !== want.remainder) begin
					$error("remainder: expected %h, actual %h", want.remainder,
						got.remainder);
					mismatch_count++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready)
			expected_quotients.push_back(divide_restoring(s_tdata[NUM_W-1:0],
				s_tdata[NUM_W+DEN_W-1:NUM_W]));
	end

	initial begin
		repeat (CYCLE_CAP) @(posedge clk);
		$display("unsigned_divide_64_by_32: mismatch");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Extremes, zero divisor, divisors at and above the top bit.
		queue_operands('0, '0);
		queue_operands('1, '0);
		queue_operands(64'h0123_4567_89AB_CDEF, '0);
		queue_operands('0, 32'd1);
		queue_operands('1, 32'd1);
		queue_operands('1, 32'd2);
		queue_operands('1, '1);
		queue_operands('0, '1);
		queue_operands(64'd1, '1);
		queue_operands(64'hFFFF_FFFE, '1);
		queue_operands(64'hFFFF_FFFF_0000_0000, '1);
		queue_operands('1, 32'h8000_0000);
		queue_operands('1, 32'h8000_0001);
		queue_operands(64'h8000_0000_0000_0000, 32'h8000_0001);
		queue_operands(64'h8000_0000_0000_0000, 32'd3);
		queue_operands('1, 32'hFFFF_FFFE);
		queue_operands(64'd5, 32'd7);
		queue_operands(64'd7, 32'd7);
		queue_operands(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
		queue_operands(64'hFFFF_FFFE_0000_0001, '1);
		queue_operands(64'h5555_5555_AAAA_AAAA, 32'hAAAA_AAAA);
		wait_for_drain();

		for (int n = 0; n < RANDOM_OPS / 2; n++)
			queue_random_operands();
		wait_for_drain();

		for (int n = 0; n < RANDOM_OPS - RANDOM_OPS / 2; n++)
			queue_random_operands();
		while (pending_operands.size() >= TAIL_OPS)
			@(posedge clk);
		tail_phase = 1'b1;
		wait_for_drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0)
			$display("unsigned_divide_64_by_32: match");
		else
			$display("unsigned_divide_64_by_32: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/udiv_pkg.sv
rtl/core/udiv_stage.sv
rtl/core/unsigned_divide_64_by_32.sv
verif/testbench.sv
